FILE: hw/rtl/dibi_pkg.sv
// Shared types and constants for the icon DIB pixel to RGBA converter.
// No dependencies; dibi_cfg_if and the pipeline modules use it by scoped names.
`timescale 1ns / 1ps

package dibi_pkg;

    localparam int PALETTE_DEPTH_DEF = 256;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PALETTE_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_PRESENT  = 2'd2;

    // Depth codes; anything above DEPTH_32BPP behaves as 32 bpp
    localparam logic [2:0] DEPTH_1BPP  = 3'd0;
    localparam logic [2:0] DEPTH_4BPP  = 3'd1;
    localparam logic [2:0] DEPTH_8BPP  = 3'd2;
    localparam logic [2:0] DEPTH_24BPP = 3'd3;
    localparam logic [2:0] DEPTH_32BPP = 3'd4;

    // Request types
    localparam logic REQ_PALETTE = 1'b0;
    localparam logic REQ_PIXEL   = 1'b1;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

    localparam logic [2:0] DEPTH_MODE_RST    = DEPTH_32BPP;
    localparam logic [8:0] PALETTE_COUNT_RST = 9'd256;
    localparam logic       MASK_PRESENT_RST  = 1'b1;

    typedef struct packed {
        logic [2:0] depth_mode;
        logic [8:0] palette_count;
        logic       mask_present;
    } cfg_t;

    // Decode stage contents
    typedef struct packed {
        logic [23:0] raw_bgr;
        logic [7:0]  raw_alpha;
        logic        use_palette;
        logic        index_ok;
        logic        wide;
        logic        transparent;
        logic        last;
    } s1_t;

    // Color select stage contents
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [7:0] mask_alpha;
        logic       wide;
        logic       alpha_nz;
        logic       last;
    } s2_t;

endpackage

FILE: hw/rtl/dibi_pix_if.sv
// Input channel: palette entry writes and pixels.
// Depends on nothing.
`timescale 1ns / 1ps

interface dibi_pix_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [7:0]  entry_index;
    logic [23:0] entry_color;
    logic [31:0] pixel_value;
    logic        and_mask;
    logic        last_pixel;

    modport source (output valid, req_type, entry_index, entry_color, pixel_value,
                    and_mask, last_pixel, input ready);
    modport sink   (input valid, req_type, entry_index, entry_color, pixel_value,
                    and_mask, last_pixel, output ready);
endinterface

FILE: hw/rtl/dibi_rgba_if.sv
// Output channel: one RGBA result per pixel.
// Depends on nothing.
`timescale 1ns / 1ps

interface dibi_rgba_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] mask_alpha;
    logic       image_end;
    logic       use_mask_alpha;

    modport source (output valid, red, green, blue, alpha, mask_alpha, image_end,
                    use_mask_alpha, input ready);
    modport sink   (input valid, red, green, blue, alpha, mask_alpha, image_end,
                    use_mask_alpha, output ready);
endinterface

FILE: hw/rtl/dibi_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on dibi_pkg for widths.
`timescale 1ns / 1ps

interface dibi_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [dibi_pkg::CFG_IDX_W-1:0]  index;
    logic [dibi_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/dibi_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module dibi_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/dibi_decode.sv
// Stage 1: accept input beats, write the palette, decode the pixel and
// launch the palette read. Depends on dibi_pkg, dibi_pix_if and dibi_ram.
`timescale 1ns / 1ps

module dibi_decode #(
    parameter int PALETTE_DEPTH = dibi_pkg::PALETTE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dibi_pkg::cfg_t       cfg,
    dibi_pix_if.sink             pixel,
    output logic                 s1_valid,
    input  logic                 s1_ready,
    output dibi_pkg::s1_t        s1,
    output logic [23:0]          pal_data
);

    localparam int AW = $clog2(PALETTE_DEPTH);

    logic          s1_valid_reg;
    logic          s1_valid_next;
    dibi_pkg::s1_t s1_reg;
    dibi_pkg::s1_t s1_next;
    logic          accept;
    logic          is_pixel;
    logic          slot_ok;
    logic          pal_we;
    logic          pal_re;
    logic [7:0]    idx;
    logic          use_palette;
    logic          wide;

    assign pixel.ready = !s1_valid_reg || s1_ready;
    assign accept      = pixel.valid && pixel.ready;
    assign is_pixel    = (pixel.req_type == dibi_pkg::REQ_PIXEL);

    // Drop palette writes aimed past the store
    assign slot_ok = ({1'b0, pixel.entry_index} < 9'(PALETTE_DEPTH));
    assign pal_we  = accept && !is_pixel && slot_ok;
    assign pal_re  = accept && is_pixel;

    always_comb
    begin
        idx         = pixel.pixel_value[7:0];
        use_palette = 1'b0;
        wide        = 1'b0;
        case (cfg.depth_mode)
            dibi_pkg::DEPTH_1BPP:
            begin
                idx         = {7'd0, pixel.pixel_value[0]};
                use_palette = 1'b1;
            end
            dibi_pkg::DEPTH_4BPP:
            begin
                idx         = {4'd0, pixel.pixel_value[3:0]};
                use_palette = 1'b1;
            end
            dibi_pkg::DEPTH_8BPP:
            begin
                use_palette = 1'b1;
            end
            dibi_pkg::DEPTH_24BPP:
            begin
                use_palette = 1'b0;
            end
            default:
            begin
                wide = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        s1_next.raw_bgr     = pixel.pixel_value[23:0];
        s1_next.raw_alpha   = pixel.pixel_value[31:24];
        s1_next.use_palette = use_palette;
        s1_next.index_ok    = ({1'b0, idx} < cfg.palette_count)
                              && ({1'b0, idx} < 9'(PALETTE_DEPTH));
        s1_next.wide        = wide;
        s1_next.transparent = cfg.mask_present && pixel.and_mask;
        s1_next.last        = pixel.last_pixel;
    end

    // Palette beats produce no result: they leave no valid bit behind
    assign s1_valid_next = accept && is_pixel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (pixel.ready)
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pal_re)
        begin
            s1_reg <= s1_next;
        end
    end

    // Read data tracks the stage register: both load only on a pixel accept
    dibi_ram #(
        .WIDTH (24),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk   (clk),
        .we    (pal_we),
        .waddr (pixel.entry_index[AW-1:0]),
        .wdata (pixel.entry_color),
        .re    (pal_re),
        .raddr (idx[AW-1:0]),
        .rdata (pal_data)
    );

    assign s1_valid = s1_valid_reg;
    assign s1       = s1_reg;

endmodule

FILE: hw/rtl/dibi_select.sv
// Stage 2: pick palette, raw or black color and form both alpha values.
// Depends on dibi_pkg.
`timescale 1ns / 1ps

module dibi_select (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s1_valid,
    output logic          s1_ready,
    input  dibi_pkg::s1_t s1,
    input  logic [23:0]   pal_data,
    output logic          s2_valid,
    input  logic          s2_ready,
    output dibi_pkg::s2_t s2
);

    logic          s2_valid_reg;
    dibi_pkg::s2_t s2_reg;
    dibi_pkg::s2_t s2_next;
    logic [23:0]   bgr;
    logic [7:0]    malpha;

    assign s1_ready = !s2_valid_reg || s2_ready;

    always_comb
    begin
        if (s1.use_palette)
        begin
            bgr = s1.index_ok ? pal_data : 24'd0;
        end
        else
        begin
            bgr = s1.raw_bgr;
        end
        malpha = s1.transparent ? dibi_pkg::ALPHA_CLEAR : dibi_pkg::ALPHA_OPAQUE;

        s2_next.blue       = bgr[7:0];
        s2_next.green      = bgr[15:8];
        s2_next.red        = bgr[23:16];
        s2_next.mask_alpha = malpha;
        s2_next.alpha      = s1.wide ? s1.raw_alpha : malpha;
        s2_next.wide       = s1.wide;
        s2_next.alpha_nz   = s1.wide && (s1.raw_alpha != 8'd0);
        s2_next.last       = s1.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s2_valid_reg <= s1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && s1_valid)
        begin
            s2_reg <= s2_next;
        end
    end

    assign s2_valid = s2_valid_reg;
    assign s2       = s2_reg;

endmodule

FILE: hw/rtl/dibi_emit.sv
// Stage 3: output register and per-image alpha tracking.
// Depends on dibi_pkg and dibi_rgba_if.
`timescale 1ns / 1ps

module dibi_emit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s2_valid,
    output logic          s2_ready,
    input  dibi_pkg::s2_t s2,
    dibi_rgba_if.source   rgba
);

    logic       out_valid_reg;
    logic       alpha_seen_reg;
    logic       alpha_seen_next;
    logic       load;
    logic       seen_now;
    logic       use_mask_next;
    logic [7:0] red_reg;
    logic [7:0] green_reg;
    logic [7:0] blue_reg;
    logic [7:0] alpha_reg;
    logic [7:0] mask_alpha_reg;
    logic       image_end_reg;
    logic       use_mask_reg;

    assign s2_ready = !out_valid_reg || rgba.ready;
    assign load     = s2_valid && s2_ready;

    // This pixel counts toward the flag before the end-of-image check
    assign seen_now        = alpha_seen_reg || s2.alpha_nz;
    assign use_mask_next   = s2.last && s2.wide && !seen_now;
    assign alpha_seen_next = s2.last ? 1'b0 : seen_now;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            alpha_seen_reg <= 1'b0;
        end
        else
        begin
            if (s2_ready)
            begin
                out_valid_reg <= s2_valid;
            end
            if (load)
            begin
                alpha_seen_reg <= alpha_seen_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            red_reg        <= s2.red;
            green_reg      <= s2.green;
            blue_reg       <= s2.blue;
            alpha_reg      <= s2.alpha;
            mask_alpha_reg <= s2.mask_alpha;
            image_end_reg  <= s2.last;
            use_mask_reg   <= use_mask_next;
        end
    end

    assign rgba.valid          = out_valid_reg;
    assign rgba.red            = red_reg;
    assign rgba.green          = green_reg;
    assign rgba.blue           = blue_reg;
    assign rgba.alpha          = alpha_reg;
    assign rgba.mask_alpha     = mask_alpha_reg;
    assign rgba.image_end      = image_end_reg;
    assign rgba.use_mask_alpha = use_mask_reg;

endmodule

FILE: hw/rtl/dib_icon_pixel_to_rgba_top.sv
// Top level of the icon DIB pixel to RGBA converter: configuration registers
// and the three pipeline stages. Depends on dibi_pkg, the channel interfaces,
// dibi_decode, dibi_select and dibi_emit.
//
//   channel  | role | payload
//   ---------+------+-------------------------------------------------------
//   pixel    | sink | req_type, entry_index, entry_color, pixel_value,
//            |      | and_mask, last_pixel
//   rgba     | src  | red, green, blue, alpha, mask_alpha, image_end,
//            |      | use_mask_alpha
//   cfg      | sink | index (0 depth_mode, 1 palette_count, 2 mask_present),
//            |      | data
//
// One beat per clock in each direction while rgba is not stalled; a pixel
// beat goes through decode + palette read, color select and the output
// register. Palette beats retire in the decode stage and produce nothing.
// Each stage holds while the one after it is full and stalled, so a stall on
// rgba backs up to pixel.ready without dropping or repeating a beat.
// Reset empties the pipeline, clears the alpha tracking flag and loads the
// register defaults; palette contents are undefined until written.
`timescale 1ns / 1ps

module dib_icon_pixel_to_rgba_top #(
    parameter int PALETTE_DEPTH = dibi_pkg::PALETTE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    dibi_pix_if.sink   pixel,
    dibi_rgba_if.source rgba,
    dibi_cfg_if.sink   cfg
);

    logic [2:0]     depth_mode_reg;
    logic [8:0]     palette_count_reg;
    logic           mask_present_reg;
    dibi_pkg::cfg_t cfg_cur;

    logic           s1_valid;
    logic           s1_ready;
    dibi_pkg::s1_t  s1;
    logic [23:0]    pal_data;
    logic           s2_valid;
    logic           s2_ready;
    dibi_pkg::s2_t  s2;

    // Register writes are always taken; unknown indexes drop silently
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_mode_reg    <= dibi_pkg::DEPTH_MODE_RST;
            palette_count_reg <= dibi_pkg::PALETTE_COUNT_RST;
            mask_present_reg  <= dibi_pkg::MASK_PRESENT_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                dibi_pkg::REG_DEPTH_MODE:    depth_mode_reg    <= cfg.data[2:0];
                dibi_pkg::REG_PALETTE_COUNT: palette_count_reg <= cfg.data[8:0];
                dibi_pkg::REG_MASK_PRESENT:  mask_present_reg  <= cfg.data[0];
                default:
                begin
                    depth_mode_reg <= depth_mode_reg;
                end
            endcase
        end
    end

    assign cfg_cur.depth_mode    = depth_mode_reg;
    assign cfg_cur.palette_count = palette_count_reg;
    assign cfg_cur.mask_present  = mask_present_reg;

    // Decode, palette write and palette read launch
    dibi_decode #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_cur),
        .pixel    (pixel),
        .s1_valid (s1_valid),
        .s1_ready (s1_ready),
        .s1       (s1),
        .pal_data (pal_data)
    );

    // Color and alpha selection
    dibi_select u_select (
        .clk      (clk),
        .rst_n    (rst_n),
        .s1_valid (s1_valid),
        .s1_ready (s1_ready),
        .s1       (s1),
        .pal_data (pal_data),
        .s2_valid (s2_valid),
        .s2_ready (s2_ready),
        .s2       (s2)
    );

    // Output register and end-of-image alpha flag
    dibi_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .s2_valid (s2_valid),
        .s2_ready (s2_ready),
        .s2       (s2),
        .rgba     (rgba)
    );

endmodule

FILE: hw/rtl/dibi_checker.sv
// Port-level checks for the converter, bound to the top level.
// Depends on dib_icon_pixel_to_rgba_top and its rgba channel interface.
`timescale 1ns / 1ps

module dibi_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] red,
    input logic [7:0] green,
    input logic [7:0] blue,
    input logic [7:0] alpha,
    input logic [7:0] mask_alpha,
    input logic       image_end,
    input logic       use_mask_alpha
);

    // Hold a stalled result beat unchanged
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green)
            && $stable(blue) && $stable(alpha) && $stable(mask_alpha)
            && $stable(image_end) && $stable(use_mask_alpha))
        else $error("result beat changed while stalled");

    a_flag_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && use_mask_alpha |-> image_end)
        else $error("use_mask_alpha outside the last pixel");

    // The last pixel of a flagged image carries zero alpha
    a_flag_zero_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && use_mask_alpha |-> alpha == 8'h00)
        else $error("use_mask_alpha with nonzero alpha");

    a_mask_alpha_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> mask_alpha == 8'h00 || mask_alpha == 8'hFF)
        else $error("mask_alpha neither clear nor opaque");

endmodule

bind dib_icon_pixel_to_rgba_top dibi_checker u_dibi_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (rgba.valid),
    .out_ready      (rgba.ready),
    .red            (rgba.red),
    .green          (rgba.green),
    .blue           (rgba.blue),
    .alpha          (rgba.alpha),
    .mask_alpha     (rgba.mask_alpha),
    .image_end      (rgba.image_end),
    .use_mask_alpha (rgba.use_mask_alpha)
);

FILE: bench/dib_icon_pixel_to_rgba_top_test.sv
// Self-checking testbench for dib_icon_pixel_to_rgba_top: directed corner cases, then
// randomized images under changing depth, palette count and mask settings.
// Depends on dibi_pkg, the three channel interfaces and the converter RTL.
`timescale 1ns / 1ps

module dib_icon_pixel_to_rgba_top_test;

    localparam int PALETTE_SLOTS = dibi_pkg::PALETTE_DEPTH_DEF;
    localparam int ITEM_TARGET   = 1600;
    localparam int RAND_PHASES   = 10;
    // Pipeline is three stages deep; leave margin before touching registers
    localparam int PIPE_SLACK    = 8;
    // Cycles without any accepted beat before the run is declared hung
    localparam int HANG_LIMIT    = 2000;

    // Register index past the end of the map; writes to it must be ignored
    localparam logic [dibi_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
    // Depth codes above 32 bpp that must alias to 32 bpp
    localparam logic [2:0] DEPTH_ALIAS_MIN = 3'd5;
    localparam logic [2:0] DEPTH_ALIAS_MAX = 3'd7;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  entry_index;
        logic [23:0] entry_color;
        logic [31:0] pixel_value;
        logic        and_mask;
        logic        last_pixel;
    } pix_beat_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [7:0] mask_alpha;
        logic       image_end;
        logic       use_mask_alpha;
    } rgba_beat_t;

    // How the alpha byte of 32 bpp pixels is drawn for one image
    typedef enum int {IMG_ALPHA_ZERO, IMG_ALPHA_SPARSE, IMG_ALPHA_RANDOM} alpha_style_t;

    logic clk = 1'b0;
    logic rst_n;

    dibi_pix_if  pixel ();
    dibi_rgba_if rgba ();
    dibi_cfg_if  cfg ();

    dib_icon_pixel_to_rgba_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pixel (pixel),
        .rgba  (rgba),
        .cfg   (cfg)
    );

    always #5 clk = ~clk;

    // Shadow of the converter: registers, palette contents and alpha tracking
    logic [2:0]  shadow_depth = dibi_pkg::DEPTH_MODE_RST;
    logic [8:0]  shadow_count = dibi_pkg::PALETTE_COUNT_RST;
    logic        shadow_mask  = dibi_pkg::MASK_PRESENT_RST;
    logic [23:0] palette_copy [PALETTE_SLOTS];
    bit          palette_loaded [PALETTE_SLOTS];
    logic        alpha_nonzero_seen = 1'b0;

    rgba_beat_t  pending_rgba [$];
    rgba_beat_t  rgba_want;

    int fail_count     = 0;
    int idle_cycles    = 0;
    int src_gap_pct    = 0;
    int sink_stall_pct = 0;

    // Mostly no gap; when there is one, mostly short, sometimes long
    function automatic int pick_gap(input int pct);
        if ($urandom_range(0, 99) >= pct)
        begin
            return 0;
        end
        if ($urandom_range(0, 99) < 85)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Only the low 1, 4 or 8 bits of the pixel value select a palette slot
    function automatic logic [7:0] pixel_index(input logic [2:0] depth, input logic [31:0] pv);
        case (depth)
            dibi_pkg::DEPTH_1BPP: return {7'b0, pv[0]};
            dibi_pkg::DEPTH_4BPP: return {4'b0, pv[3:0]};
            default:              return pv[7:0];
        endcase
    endfunction

    // Update the shadow for one accepted pixel-channel beat and queue the
    // RGBA result it must produce (palette beats produce none).
    function automatic void convert_pixel(input pix_beat_t b);
        rgba_beat_t  r;
        logic [23:0] color;
        logic [7:0]  idx;
        logic        wide;
        if (b.req_type == dibi_pkg::REQ_PALETTE)
        begin
            palette_copy[b.entry_index]   = b.entry_color;
            palette_loaded[b.entry_index] = 1'b1;
            return;
        end
        wide = (shadow_depth >= dibi_pkg::DEPTH_32BPP);
        r.mask_alpha     = (shadow_mask && b.and_mask) ? dibi_pkg::ALPHA_CLEAR
                                                       : dibi_pkg::ALPHA_OPAQUE;
        r.image_end      = b.last_pixel;
        r.use_mask_alpha = 1'b0;
        if (wide)
        begin
            {r.alpha, r.red, r.green, r.blue} = b.pixel_value;
            if (r.alpha != dibi_pkg::ALPHA_CLEAR)
            begin
                alpha_nonzero_seen = 1'b1;
            end
        end
        else
        begin
            color = 24'h0;
            if (shadow_depth == dibi_pkg::DEPTH_24BPP)
            begin
                color = b.pixel_value[23:0];
            end
            else
            begin
                idx = pixel_index(shadow_depth, b.pixel_value);
                // out-of-range index gives black
                if ({1'b0, idx} < shadow_count)
                begin
                    color = palette_copy[idx];
                end
            end
            {r.red, r.green, r.blue} = color;
            r.alpha = r.mask_alpha;
        end
        if (b.last_pixel)
        begin
            r.use_mask_alpha   = wide && !alpha_nonzero_seen;
            alpha_nonzero_seen = 1'b0;
        end
        pending_rgba = {pending_rgba, r};
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Present one beat on the pixel channel after a random gap and hold it
    // until taken. Valid stays high on return so a following beat can go
    // back to back; settle() drops it.
    task automatic send_beat(input pix_beat_t b);
        int gap;
        gap = pick_gap(src_gap_pct);
        if (gap > 0)
        begin
            pixel.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel.valid       <= 1'b1;
        pixel.req_type    <= b.req_type;
        pixel.entry_index <= b.entry_index;
        pixel.entry_color <= b.entry_color;
        pixel.pixel_value <= b.pixel_value;
        pixel.and_mask    <= b.and_mask;
        pixel.last_pixel  <= b.last_pixel;
        do
            @(posedge clk);
        while (!pixel.ready);
        convert_pixel(b);
    endtask

    // Fields that the beat type does not use carry random noise
    task automatic send_pixel(input logic [31:0] pv, input logic mbit, input logic last);
        pix_beat_t b;
        b.req_type    = dibi_pkg::REQ_PIXEL;
        b.entry_index = 8'($urandom);
        b.entry_color = 24'($urandom);
        b.pixel_value = pv;
        b.and_mask    = mbit;
        b.last_pixel  = last;
        send_beat(b);
    endtask

    task automatic send_entry(input logic [7:0] slot, input logic [23:0] color);
        pix_beat_t b;
        b.req_type    = dibi_pkg::REQ_PALETTE;
        b.entry_index = slot;
        b.entry_color = color;
        b.pixel_value = $urandom;
        b.and_mask    = 1'($urandom);
        b.last_pixel  = 1'($urandom);
        send_beat(b);
    endtask

    // Drop valid, wait for every pending result, then let trailing palette
    // beats drain out of the pipeline.
    task automatic settle();
        pixel.valid <= 1'b0;
        while (pending_rgba.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (PIPE_SLACK) @(posedge clk);
    endtask

    // Write one register; call only while the converter is idle
    task automatic write_reg(input logic [dibi_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dibi_pkg::CFG_DATA_W-1:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        do
            @(posedge clk);
        while (!cfg.ready);
        case (idx)
            dibi_pkg::REG_DEPTH_MODE:    shadow_depth = data[2:0];
            dibi_pkg::REG_PALETTE_COUNT: shadow_count = data;
            dibi_pkg::REG_MASK_PRESENT:  shadow_mask  = data[0];
            default:                     ;
        endcase
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Register defaults: 32 bpp, mask present. Alpha comes from the pixel
    // and the end-of-image flag reports an all-zero alpha image.
    task automatic test_reset_defaults();
        send_pixel(32'hFFFF_FFFF, 1'b1, 1'b0);
        send_pixel(32'h0000_0000, 1'b1, 1'b1);   // alpha was seen: flag clear
        send_pixel(32'h00A5_5A3C, 1'b0, 1'b0);
        send_pixel(32'h0000_0000, 1'b0, 1'b1);   // all alpha zero: flag set
        settle();
    endtask

    // Indexed depths: index width, palette count limits, and a slot
    // rewritten right before a pixel reads it.
    task automatic test_indexed_palette();
        write_reg(dibi_pkg::REG_DEPTH_MODE, 9'(dibi_pkg::DEPTH_1BPP));
        write_reg(dibi_pkg::REG_PALETTE_COUNT, 9'd2);
        write_reg(dibi_pkg::REG_MASK_PRESENT, 9'd1);
        send_entry(8'd0, 24'h00_0000);
        send_entry(8'd1, 24'hFF_FFFF);
        send_entry(8'd15, 24'h12_3456);
        send_entry(8'd255, 24'hAB_CDEF);
        send_pixel(32'hFFFF_FFFE, 1'b1, 1'b0);   // upper bits ignored: slot 0
        send_pixel(32'h0000_0001, 1'b0, 1'b0);
        send_entry(8'd1, 24'h5A_A55A);
        send_pixel(32'h0000_0001, 1'b0, 1'b1);   // must see the new color
        settle();
        write_reg(dibi_pkg::REG_PALETTE_COUNT, 9'd1);
        send_pixel(32'h0000_0001, 1'b0, 1'b1);   // slot at the count: black
        settle();
        write_reg(dibi_pkg::REG_PALETTE_COUNT, 9'd0);
        send_pixel(32'h0000_0000, 1'b1, 1'b1);   // empty palette: black
        settle();
        write_reg(dibi_pkg::REG_DEPTH_MODE, 9'(dibi_pkg::DEPTH_4BPP));
        write_reg(dibi_pkg::REG_PALETTE_COUNT, 9'd256);
        send_pixel(32'hFFFF_FF0F, 1'b1, 1'b0);
        settle();
        write_reg(dibi_pkg::REG_DEPTH_MODE, 9'(dibi_pkg::DEPTH_8BPP));
        send_pixel(32'h0000_00FF, 1'b0, 1'b0);
        settle();
        write_reg(dibi_pkg::REG_PALETTE_COUNT, 9'd255);
        send_pixel(32'hFFFF_FFFF, 1'b0, 1'b1);   // top slot past the count
        settle();
    endtask

    // 24 bpp: high byte ignored, alpha from the mask, mask switched off
    task automatic test_truecolor();
        write_reg(dibi_pkg::REG_DEPTH_MODE, 9'(dibi_pkg::DEPTH_24BPP));
        write_reg(dibi_pkg::REG_MASK_PRESENT, 9'd0);
        send_pixel(32'hFFFF_FFFF, 1'b1, 1'b0);
        send_pixel(32'h0000_0000, 1'b1, 1'b1);   // not 32 bpp: flag clear
        settle();
    endtask

    // Unused depth codes alias to 32 bpp; a write past the map changes nothing
    task automatic test_depth_aliases();
        write_reg(REG_UNMAPPED, 9'h1FF);
        write_reg(dibi_pkg::REG_MASK_PRESENT, 9'd1);
        write_reg(dibi_pkg::REG_DEPTH_MODE, 9'(DEPTH_ALIAS_MAX));
        send_pixel(32'h00FF_FFFF, 1'b1, 1'b0);
        send_pixel(32'h0000_0000, 1'b0, 1'b1);
        settle();
        write_reg(dibi_pkg::REG_DEPTH_MODE, 9'(DEPTH_ALIAS_MIN));
        send_pixel(32'h8000_0000, 1'b1, 1'b1);
        settle();
    endtask

    // Whole images under a new register setting per phase. Every phase
    // opens with a full drain, so the sender regularly waits for all
    // results. Palette slots get written before a pixel reads them.
    task automatic test_random_images(input int total);
        int           per_phase;
        int           lim;
        logic [2:0]   depth;
        logic [5:0]   junk;
        logic [8:0]   count;
        logic [31:0]  pv;
        logic [7:0]   idx;
        logic         last;
        alpha_style_t style;
        per_phase = total / RAND_PHASES;
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            settle();
            depth = (ph < 8) ? 3'(ph) : 3'($urandom_range(0, 7));
            junk  = 6'($urandom);
            case (ph % 6)
                0:       count = 9'd256;
                1:       count = 9'd0;
                2:       count = 9'd1;
                3:       count = 9'd511;
                4:       count = 9'd255;
                default: count = 9'($urandom_range(2, 511));
            endcase
            // upper data bits of the depth write are don't-care
            write_reg(dibi_pkg::REG_DEPTH_MODE, {junk, depth});
            write_reg(dibi_pkg::REG_PALETTE_COUNT, count);
            write_reg(dibi_pkg::REG_MASK_PRESENT, 9'($urandom_range(0, 1)));
            // every third phase runs at full rate on both sides
            src_gap_pct    = (ph % 3 == 0) ? 0 : 30;
            sink_stall_pct = (ph % 3 == 0) ? 0 : 35;
            style = alpha_style_t'($urandom_range(0, 2));
            lim   = (count > 9'd256) ? 256 : int'(count);
            for (int k = 0; k < per_phase; k++)
            begin
                if ($urandom_range(0, 99) < 12)
                begin
                    send_entry(8'($urandom), 24'($urandom));
                    continue;
                end
                pv = $urandom;
                if (style == IMG_ALPHA_ZERO ||
                    (style == IMG_ALPHA_SPARSE && $urandom_range(0, 7) != 0))
                begin
                    pv[31:24] = 8'h00;
                end
                // bias half the indices into the valid range
                if (lim > 0 && $urandom_range(0, 1) == 1)
                begin
                    pv[7:0] = 8'($urandom_range(0, lim - 1));
                end
                if (depth < dibi_pkg::DEPTH_24BPP)
                begin
                    idx = pixel_index(depth, pv);
                    if ({1'b0, idx} < count && !palette_loaded[idx])
                    begin
                        send_entry(idx, 24'($urandom));
                    end
                end
                // close the image at the end of the phase
                last = (k == per_phase - 1) || ($urandom_range(0, 9) == 0);
                send_pixel(pv, 1'($urandom_range(0, 1)), last);
                if (last)
                begin
                    style = alpha_style_t'($urandom_range(0, 2));
                end
            end
        end
        src_gap_pct    = 0;
        sink_stall_pct = 0;
    endtask

    // Result ready: random stalls, mostly short, a few long
    initial
    begin : rgba_pacing
        int stall;
        rgba.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            stall = pick_gap(sink_stall_pct);
            if (stall > 0)
            begin
                rgba.ready <= 1'b0;
                repeat (stall) @(posedge clk);
                rgba.ready <= 1'b1;
            end
        end
    end

    // Compare each taken result beat with the oldest pending one
    always @(posedge clk)
    begin
        if (rst_n && rgba.valid && rgba.ready)
        begin
            if (pending_rgba.size() == 0)
            begin
                $error("rgba beat with no pending pixel");
                fail_count++;
            end
            else
            begin
                rgba_want = pending_rgba.pop_front();
                check_field("red", rgba_want.red, rgba.red);
                check_field("green", rgba_want.green, rgba.green);
                check_field("blue", rgba_want.blue, rgba.blue);
                check_field("alpha", rgba_want.alpha, rgba.alpha);
                check_field("mask_alpha", rgba_want.mask_alpha, rgba.mask_alpha);
                check_field("image_end", {7'b0, rgba_want.image_end}, {7'b0, rgba.image_end});
                check_field("use_mask_alpha", {7'b0, rgba_want.use_mask_alpha},
                            {7'b0, rgba.use_mask_alpha});
            end
        end
    end

    // Hang detector: restart on any taken beat on any channel
    always @(posedge clk)
    begin
        if ((pixel.valid && pixel.ready) || (rgba.valid && rgba.ready) ||
            (cfg.valid && cfg.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= HANG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        // hold every input at a known value through reset
        rst_n             <= 1'b0;
        pixel.valid       <= 1'b0;
        pixel.req_type    <= dibi_pkg::REQ_PALETTE;
        pixel.entry_index <= 8'h00;
        pixel.entry_color <= 24'h0;
        pixel.pixel_value <= 32'h0;
        pixel.and_mask    <= 1'b0;
        pixel.last_pixel  <= 1'b0;
        cfg.valid         <= 1'b0;
        cfg.index         <= dibi_pkg::REG_DEPTH_MODE;
        cfg.data          <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_indexed_palette();
        test_truecolor();
        test_depth_aliases();
        test_random_images(ITEM_TARGET);
        settle();

        if (fail_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
